// File: rtl/skv_pkg.sv
// Shared types and constants for the sorted key/value table unit.
// Holds the status codes, controller states and the command/status structs.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package skv_pkg;

	// Default sizes of the table and its payload.
	localparam int DEF_CAPACITY   = 8;
	localparam int DEF_KEY_BITS   = 48;
	localparam int DEF_VALUE_BITS = 32;

	// Fixed widths of the index and entry count fields.
	localparam int INDEX_BITS = 3;
	localparam int COUNT_BITS = 4;

	// Request kinds.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_READ_OK   = 3'd3,
		ST_BAD_INDEX = 3'd4
	} skv_status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SHIFT,
		S_PLACE,
		S_READ,
		S_RESULT
	} skv_state_t;

	// Table read operations issued by the controller.
	typedef enum logic [2:0] {
		RD_NONE,
		RD_INDEX,
		RD_FIRST,
		RD_NEXT,
		RD_TAIL,
		RD_PREV
	} skv_rd_op_t;

	// Table write operations issued by the controller.
	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT,
		WR_PLACE
	} skv_wr_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        capture;
		skv_rd_op_t  rd_op;
		skv_wr_op_t  wr_op;
		logic        set_pos_end;
		logic        status_we;
		skv_status_t status_code;
		logic        load_out;
	} skv_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
		logic full;
		logic empty;
		logic index_ok;
		logic key_eq;
		logic key_gt;
		logic scan_last;
		logic shift_last;
		logic out_free;
	} skv_sts_t;

endpackage

`default_nettype wire

// File: rtl/sorted_key_value_table_unit.sv
// Sorted key/value table unit: a fixed-capacity map kept in ascending key order.
// Request channel: in_valid/in_stall with kind, key, value and index. An insert
// (kind 0) adds key/value in order, or reports duplicate key or table full. A
// read (kind 1) returns the entry at a sorted index, or index out of range.
// Result channel: out_valid/out_stall with status, out_key, out_value and
// entry_count, one result per request, in request order.
// One request is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register, and the next request can be taken
// in the cycle after that.
// The entry memory has one read and one write port, one entry per cycle. Steps:
//   read: index check, entry fetch, result; a bad index skips the fetch.
//   insert: full check, scan from the first entry to the first larger key, shift
//   of the entries from the tail down to that slot one slot up, placement; a
//   duplicate ends at the matching entry, a full table skips to the result and
//   an empty table goes straight to placement.
// The next request is accepted while a result waits in the output register;
// a stalled result holds, and a finished request waits until the slot frees.
// Reset clears the entry count and the result valid; the memory is not cleared.
`default_nettype none

module sorted_key_value_table_unit #(
	parameter int CAPACITY   = skv_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = skv_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = skv_pkg::DEF_VALUE_BITS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            kind,
	input  wire  [KEY_BITS-1:0]            key,
	input  wire  [VALUE_BITS-1:0]          value,
	input  wire  [skv_pkg::INDEX_BITS-1:0] index,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [2:0]                     status,
	output logic [KEY_BITS-1:0]            out_key,
	output logic [VALUE_BITS-1:0]          out_value,
	output logic [skv_pkg::COUNT_BITS-1:0] entry_count
);
	import skv_pkg::*;

	skv_cmd_t dp_cmd;
	skv_sts_t dp_sts;

	// Controller.
	skv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// Datapath.
	skv_datapath #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.index       (index),
		.out_stall   (out_stall),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.out_valid   (out_valid),
		.status      (status),
		.out_key     (out_key),
		.out_value   (out_value),
		.entry_count (entry_count)
	);

`ifndef SYNTHESIS
	// An accepted request blocks the channel until its result is loaded.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request channel open while a request is in work");

	// Only a successful read carries key and value.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_READ_OK) |-> (out_key == '0 && out_value == '0))
		else $error("nonzero key or value on a result that is not a read");

	// The table is never written while it is full.
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.wr_op != WR_NONE) |-> !dp_sts.full)
		else $error("table written while full");

	// A result is only loaded when the output register is free.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result loaded over a stalled result");
`endif

`default_nettype wire
endmodule

// File: rtl/skv_ctrl.sv
// Controller state machine of the sorted key/value table unit.
// Sequences the checks, the indexed read, the scan, shift and placement steps and the result handoff.
// Depends on skv_pkg.
`default_nettype none

module skv_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  skv_pkg::skv_sts_t sts,
	output skv_pkg::skv_cmd_t cmd
);
	import skv_pkg::*;

	skv_state_t state_q;
	skv_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d         = state_q;
		in_stall        = 1'b1;
		cmd             = '0;
		cmd.rd_op       = RD_NONE;
		cmd.wr_op       = WR_NONE;
		cmd.status_code = ST_INSERTED;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_read) begin
					if (sts.index_ok) begin
						cmd.rd_op = RD_INDEX;
						state_d   = S_READ;
					end else begin
						cmd.status_we   = 1'b1;
						cmd.status_code = ST_BAD_INDEX;
						state_d         = S_RESULT;
					end
				end else if (sts.full) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = ST_FULL;
					state_d         = S_RESULT;
				end else if (sts.empty) begin
					cmd.set_pos_end = 1'b1;
					state_d         = S_PLACE;
				end else begin
					cmd.rd_op = RD_FIRST;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				// The entry at the scan pointer is in the read register.
				if (sts.key_eq) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = ST_DUPLICATE;
					state_d         = S_RESULT;
				end else if (sts.key_gt) begin
					cmd.rd_op = RD_TAIL;
					state_d   = S_SHIFT;
				end else if (sts.scan_last) begin
					cmd.set_pos_end = 1'b1;
					state_d         = S_PLACE;
				end else begin
					cmd.rd_op = RD_NEXT;
				end
			end
			S_SHIFT: begin
				// Move one entry up a slot while fetching the one below it, if any is left to move.
				cmd.wr_op = WR_SHIFT;
				if (sts.shift_last) begin
					state_d = S_PLACE;
				end else begin
					cmd.rd_op = RD_PREV;
				end
			end
			S_PLACE: begin
				cmd.wr_op       = WR_PLACE;
				cmd.status_we   = 1'b1;
				cmd.status_code = ST_INSERTED;
				state_d         = S_RESULT;
			end
			S_READ: begin
				cmd.status_we   = 1'b1;
				cmd.status_code = ST_READ_OK;
				state_d         = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`default_nettype wire
endmodule

// File: rtl/skv_datapath.sv
// Datapath of the sorted key/value table unit: entry memory, request and
// pointer registers, key compare, entry count and the result register.
// Depends on skv_pkg.
`default_nettype none

module skv_datapath #(
	parameter int CAPACITY   = skv_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = skv_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = skv_pkg::DEF_VALUE_BITS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               kind,
	input  wire  [KEY_BITS-1:0]               key,
	input  wire  [VALUE_BITS-1:0]             value,
	input  wire  [skv_pkg::INDEX_BITS-1:0]    index,
	input  wire                               out_stall,
	input  skv_pkg::skv_cmd_t                 cmd,
	output skv_pkg::skv_sts_t                 sts,
	output logic                              out_valid,
	output logic [2:0]                        status,
	output logic [KEY_BITS-1:0]               out_key,
	output logic [VALUE_BITS-1:0]             out_value,
	output logic [skv_pkg::COUNT_BITS-1:0]    entry_count
);
	import skv_pkg::*;

	localparam int AW     = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

	// Entry memory, key in the upper bits.
	logic [ENTRY_W-1:0] mem [CAPACITY];
	logic [ENTRY_W-1:0] rd_data_q;

	// Request registers.
	logic                  kind_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [INDEX_BITS-1:0] index_q;

	// Control state of the table.
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    pos_q;
	skv_status_t      res_status_q;
	logic             out_valid_q;

	// Result payload registers.
	logic [2:0]            status_q;
	logic [KEY_BITS-1:0]   out_key_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic [COUNT_BITS-1:0] entry_count_q;

	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [ENTRY_W-1:0]      wr_data;
	logic [AW-1:0]           ptr_d;
	logic [AW-1:0]           tail;
	logic [KEY_BITS-1:0]     rd_key;
	logic [VALUE_BITS-1:0]   rd_value;
	logic [INDEX_BITS+CNT_W-1:0] idx_cmp;
	logic [INDEX_BITS+CNT_W-1:0] cnt_cmp;
	logic [INDEX_BITS+AW-1:0]    idx_addr;
	logic [COUNT_BITS+CNT_W-1:0] cnt_ext;

	assign rd_key   = rd_data_q[ENTRY_W-1:VALUE_BITS];
	assign rd_value = rd_data_q[VALUE_BITS-1:0];
	assign tail     = AW'(count_q - CNT_W'(1));
	assign idx_cmp  = {{CNT_W{1'b0}}, index_q};
	assign cnt_cmp  = {{INDEX_BITS{1'b0}}, count_q};
	assign idx_addr = {{AW{1'b0}}, index_q};
	assign cnt_ext  = {{COUNT_BITS{1'b0}}, count_q};

	// Status toward the controller.
	always_comb begin
		sts.is_read    = (kind_q == KIND_READ);
		sts.full       = (count_q == CNT_W'(CAPACITY));
		sts.empty      = (count_q == '0);
		sts.index_ok   = (idx_cmp < cnt_cmp);
		sts.key_eq     = (rd_key == key_q);
		sts.key_gt     = (rd_key > key_q);
		sts.scan_last  = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
		sts.shift_last = (ptr_q == pos_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Read address and pointer update for each read operation.
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = ptr_q;
		ptr_d   = ptr_q;
		case (cmd.rd_op)
			RD_INDEX: begin
				rd_addr = idx_addr[AW-1:0];
			end
			RD_FIRST: begin
				rd_addr = '0;
				ptr_d   = '0;
			end
			RD_NEXT: begin
				rd_addr = ptr_q + AW'(1);
				ptr_d   = ptr_q + AW'(1);
			end
			RD_TAIL: begin
				rd_addr = tail;
				ptr_d   = tail;
			end
			RD_PREV: begin
				rd_addr = ptr_q - AW'(1);
				ptr_d   = ptr_q - AW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Write address and data: a shift moves the fetched entry up one slot.
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = pos_q;
		wr_data = {key_q, value_q};
		case (cmd.wr_op)
			WR_SHIFT: begin
				wr_addr = ptr_q + AW'(1);
				wr_data = rd_data_q;
			end
			WR_PLACE: begin
				wr_addr = pos_q;
				wr_data = {key_q, value_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Request, pointer and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
			index_q <= index;
		end
		ptr_q <= ptr_d;
		if (cmd.rd_op == RD_TAIL) begin
			pos_q <= ptr_q;
		end else if (cmd.set_pos_end) begin
			pos_q <= AW'(count_q);
		end
		if (cmd.status_we) begin
			res_status_q <= cmd.status_code;
		end
		if (cmd.load_out) begin
			status_q      <= res_status_q;
			entry_count_q <= cnt_ext[COUNT_BITS-1:0];
			if (res_status_q == ST_READ_OK) begin
				out_key_q   <= rd_key;
				out_value_q <= rd_value;
			end else begin
				out_key_q   <= '0;
				out_value_q <= '0;
			end
		end
	end

	// Entry count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_op == WR_PLACE) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_key     = out_key_q;
	assign out_value   = out_value_q;
	assign entry_count = entry_count_q;

`default_nettype wire
endmodule

// File: dv/kv_table_tracker_pkg.sv
// Result tracker for the sorted key/value table testbench.
// Holds its own copy of the sorted table, predicts each result and checks it.
// Depends on skv_pkg for the status codes, request kinds and field sizes.
`timescale 1ns / 100ps

package kv_table_tracker_pkg;

	import skv_pkg::*;

	localparam int TABLE_DEPTH = DEF_CAPACITY;
	localparam int KEY_W       = DEF_KEY_BITS;
	localparam int VALUE_W     = DEF_VALUE_BITS;

	// One result as the block should report it.
	typedef struct packed {
		skv_status_t            status;
		logic [KEY_W-1:0]       key;
		logic [VALUE_W-1:0]     value;
		logic [COUNT_BITS-1:0]  count;
	} table_result_t;

	class kv_table_tracker;

		// Mirror of the table; only slots below held_count are ever looked at.
		bit [KEY_W-1:0]   held_keys[TABLE_DEPTH];
		bit [VALUE_W-1:0] held_values[TABLE_DEPTH];
		int unsigned      held_count;

		table_result_t    pending[$];
		int unsigned      errors;
		int unsigned      requests;
		int unsigned      results;
		int unsigned      status_hits[5];

		function new();
			held_count = 0;
			errors = 0;
			requests = 0;
			results = 0;
			foreach (status_hits[s]) status_hits[s] = 0;
		endfunction

		// Applies an accepted request to the mirror and queues its result.
		function void note_request(logic kind, logic [KEY_W-1:0] key,
				logic [VALUE_W-1:0] value, logic [INDEX_BITS-1:0] index);
			table_result_t r;
			bit            dup;
			int unsigned   pos;
			int unsigned   i;

			r = '0;
			requests++;
			if (kind == KIND_INSERT) begin
				// The full check wins over the duplicate check.
				if (held_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					dup = 1'b0;
					for (i = 0; i < held_count; i++)
						if (held_keys[i] == key) dup = 1'b1;
					if (dup) begin
						r.status = ST_DUPLICATE;
					end else begin
						// Find the first larger key and open a slot there.
						pos = 0;
						while (pos < held_count && held_keys[pos] < key) pos++;
						for (i = held_count; i > pos; i--) begin
							held_keys[i] = held_keys[i-1];
							held_values[i] = held_values[i-1];
						end
						held_keys[pos] = key;
						held_values[pos] = value;
						held_count++;
						r.status = ST_INSERTED;
					end
				end
			end else if (index < held_count) begin
				r.status = ST_READ_OK;
				r.key = held_keys[index];
				r.value = held_values[index];
			end else begin
				r.status = ST_BAD_INDEX;
			end
			r.count = held_count[COUNT_BITS-1:0];
			pending.push_back(r);
		endfunction

		// Reports one wrong field.
		function void flag_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
			end
		endfunction

		// Compares an accepted result with the oldest expectation.
		function void check_result(logic [2:0] status, logic [KEY_W-1:0] key,
				logic [VALUE_W-1:0] value, logic [COUNT_BITS-1:0] count);
			table_result_t r;

			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, actual status %0d",
					$time, status);
			end else begin
				r = pending.pop_front();
				results++;
				status_hits[r.status]++;
				flag_field("status", 64'(r.status), 64'(status));
				flag_field("out_key", 64'(r.key), 64'(key));
				flag_field("out_value", 64'(r.value), 64'(value));
				flag_field("entry_count", 64'(r.count), 64'(count));
			end
		endfunction

	endclass

endpackage

// File: dv/tb.sv
// Testbench top for the sorted key/value table unit.
// Fills the table with directed requests, then runs random requests under
// varying idle and stall patterns. Depends on skv_pkg and kv_table_tracker_pkg.
`timescale 1ns / 100ps

module tb;

	import skv_pkg::*;
	import kv_table_tracker_pkg::*;

	localparam int RANDOM_REQUESTS = 1030;
	localparam int LONG_HOLD       = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  kind = KIND_INSERT;
	logic [KEY_W-1:0]      key = '0;
	logic [VALUE_W-1:0]    value = '0;
	logic [INDEX_BITS-1:0] index = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            status;
	logic [KEY_W-1:0]      out_key;
	logic [VALUE_W-1:0]    out_value;
	logic [COUNT_BITS-1:0] entry_count;

	int unsigned send_idle_pct = 14;
	int unsigned recv_idle_pct = 67;
	int unsigned hold_asked = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	kv_table_tracker tracker = new();

	sorted_key_value_table_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.index       (index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_key     (out_key),
		.out_value   (out_value),
		.entry_count (entry_count)
	);

	always #5 clk = ~clk;

	// Result side: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_seen) begin
			hold_seen <= hold_asked;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(status, out_key, out_value, entry_count);
	end

	// Offers one request, with random idle cycles first, and waits for acceptance.
	task automatic send_request(logic k, logic [KEY_W-1:0] kk, logic [VALUE_W-1:0] vv,
			logic [INDEX_BITS-1:0] ii);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		key <= kk;
		value <= vv;
		index <= ii;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_request(k, kk, vv, ii);
	endtask

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		int n;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty read, ordered inserts at front, middle and end,
		// duplicates, reads in and out of range, then a full table.
		send_request(KIND_READ, 48'h1234_5678_9ABC, 32'h0, 3'd0);
		send_request(KIND_INSERT, 48'h8000_0000_0000, 32'hFFFF_FFFF, 3'd7);
		send_request(KIND_INSERT, 48'h0, 32'h0, 3'd0);
		send_request(KIND_INSERT, 48'hFFFF_FFFF_FFFF, 32'hA5A5_A5A5, 3'd5);
		send_request(KIND_INSERT, 48'h0, 32'h1, 3'd2);
		send_request(KIND_INSERT, 48'hFFFF_FFFF_FFFF, 32'h0, 3'd1);
		send_request(KIND_READ, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
		send_request(KIND_READ, 48'h0, 32'h0, 3'd1);
		send_request(KIND_READ, 48'h0, 32'h0, 3'd2);
		send_request(KIND_READ, 48'h0, 32'h0, 3'd3);
		send_request(KIND_INSERT, 48'h1, 32'h1, 3'd4);
		send_request(KIND_INSERT, 48'h7FFF_FFFF_FFFF, 32'h8000_0000, 3'd0);
		send_request(KIND_INSERT, 48'h5555_5555_5555, 32'h5555_5555, 3'd3);
		send_request(KIND_INSERT, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 3'd6);
		send_request(KIND_READ, 48'h0, 32'h0, 3'd6);
		send_request(KIND_INSERT, 48'hFFFF_FFFF_FFFE, 32'h7FFF_FFFF, 3'd2);
		send_request(KIND_INSERT, 48'h0000_0000_1234, 32'h1234, 3'd0);
		send_request(KIND_INSERT, 48'h0, 32'hFFFF_FFFF, 3'd7);
		send_request(KIND_READ, 48'h0, 32'h0, 3'd7);
		send_request(KIND_READ, 48'h0, 32'h0, 3'd0);
		send_request(KIND_READ, 48'h0, 32'h0, 3'd4);

		// Random requests in three idle phases; the last one starts with a long hold-off.
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 3) begin
				send_idle_pct = 67;
				recv_idle_pct <= 14;
			end
			if (n == 2 * RANDOM_REQUESTS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
				hold_asked <= hold_asked + 1;
			end
			send_request(1'($urandom_range(1)), KEY_W'({$urandom, $urandom}),
				$urandom, INDEX_BITS'($urandom_range(7)));
		end
		in_valid <= 1'b0;

		// Drain, then give a stray result time to show up.
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("run covered %0d requests and %0d checked results",
			tracker.requests, tracker.results);
		$display("inserted %0d, duplicate %0d, full %0d, read ok %0d, bad index %0d",
			tracker.status_hits[ST_INSERTED], tracker.status_hits[ST_DUPLICATE],
			tracker.status_hits[ST_FULL], tracker.status_hits[ST_READ_OK],
			tracker.status_hits[ST_BAD_INDEX]);
		if (tracker.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
